// ===== src/b32c_pkg.sv =====
`timescale 1ns / 1ps

package b32c_pkg;

   // Bit limit ceiling; dest_bits is saturated to this
   localparam logic [12:0] MAX_BITS = 13'd4096;

   // Configuration register indexes
   localparam logic CSR_CRC_GROUP = 1'b0;
   localparam logic CSR_DEST_BITS = 1'b1;

   // Result kinds
   localparam logic KIND_DATA   = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   // Characters that are skipped
   localparam logic [7:0] CHAR_SPACE  = 8'h20;
   localparam logic [7:0] CHAR_WS_LO  = 8'h09;
   localparam logic [7:0] CHAR_WS_HI  = 8'h0D;
   localparam logic [7:0] CHAR_DASH   = 8'h2D;

   typedef enum logic [1:0] {
      STATUS_OK         = 2'd0,
      STATUS_BAD_SYMBOL = 2'd1,
      STATUS_CRC_ERROR  = 2'd2,
      STATUS_INCOMPLETE = 2'd3
   } status_type;

   // One result item
   typedef struct packed {
      logic        kind;
      logic [7:0]  byte_value;
      logic [8:0]  byte_index;
      logic [1:0]  status;
      logic [12:0] bit_count;
      logic        last;
   } rsp_item_type;

   // Results of one step of the decoder core
   typedef struct packed {
      logic [1:0]   count;
      rsp_item_type item0;
      rsp_item_type item1;
   } step_out_type;

   // Alphabet lookup: bit 5 set when the character is a symbol
   function automatic logic [5:0] symbol_of(input logic [7:0] c);
      logic [5:0] r;
      r = 6'd0;
      case (c)
         "A": r = {1'b1, 5'd0};
         "B": r = {1'b1, 5'd1};
         "C": r = {1'b1, 5'd2};
         "D": r = {1'b1, 5'd3};
         "E": r = {1'b1, 5'd4};
         "F": r = {1'b1, 5'd5};
         "G": r = {1'b1, 5'd6};
         "H": r = {1'b1, 5'd7};
         "J": r = {1'b1, 5'd8};
         "K": r = {1'b1, 5'd9};
         "L": r = {1'b1, 5'd10};
         "M": r = {1'b1, 5'd11};
         "N": r = {1'b1, 5'd12};
         "P": r = {1'b1, 5'd13};
         "Q": r = {1'b1, 5'd14};
         "R": r = {1'b1, 5'd15};
         "S": r = {1'b1, 5'd16};
         "T": r = {1'b1, 5'd17};
         "U": r = {1'b1, 5'd18};
         "V": r = {1'b1, 5'd19};
         "W": r = {1'b1, 5'd20};
         "X": r = {1'b1, 5'd21};
         "Y": r = {1'b1, 5'd22};
         "Z": r = {1'b1, 5'd23};
         "2": r = {1'b1, 5'd24};
         "3": r = {1'b1, 5'd25};
         "4": r = {1'b1, 5'd26};
         "5": r = {1'b1, 5'd27};
         "6": r = {1'b1, 5'd28};
         "7": r = {1'b1, 5'd29};
         "8": r = {1'b1, 5'd30};
         "9": r = {1'b1, 5'd31};
         default: r = 6'd0;
      endcase
      return r;
   endfunction

   // Low nibble table of the CRC5 step
   function automatic logic [4:0] crc_lo(input logic [3:0] n);
      logic [4:0] r;
      r = 5'h00;
      case (n)
         4'h0: r = 5'h00;
         4'h1: r = 5'h0E;
         4'h2: r = 5'h1C;
         4'h3: r = 5'h12;
         4'h4: r = 5'h11;
         4'h5: r = 5'h1F;
         4'h6: r = 5'h0D;
         4'h7: r = 5'h03;
         4'h8: r = 5'h0B;
         4'h9: r = 5'h05;
         4'hA: r = 5'h17;
         4'hB: r = 5'h19;
         4'hC: r = 5'h1A;
         4'hD: r = 5'h14;
         4'hE: r = 5'h06;
         default: r = 5'h08;
      endcase
      return r;
   endfunction

   // High nibble table; only entries 0 and 1 are reachable with 5-bit inputs
   function automatic logic [4:0] crc_hi(input logic [3:0] n);
      logic [4:0] r;
      r = 5'h00;
      case (n)
         4'h0: r = 5'h00;
         4'h1: r = 5'h16;
         4'h2: r = 5'h05;
         4'h3: r = 5'h13;
         4'h4: r = 5'h0A;
         4'h5: r = 5'h1C;
         4'h6: r = 5'h0F;
         4'h7: r = 5'h19;
         4'h8: r = 5'h14;
         4'h9: r = 5'h02;
         4'hA: r = 5'h11;
         4'hB: r = 5'h07;
         4'hC: r = 5'h1E;
         4'hD: r = 5'h08;
         4'hE: r = 5'h1B;
         default: r = 5'h0D;
      endcase
      return r;
   endfunction

   function automatic logic [4:0] crc5_step(input logic [4:0] sym, input logic [4:0] prev);
      logic [4:0] t;
      t = sym ^ prev;
      return crc_lo(t[3:0]) ^ crc_hi({3'b000, t[4]});
   endfunction

endpackage

// ===== src/b32c_core.sv =====
`timescale 1ns / 1ps

// Per-string decoder state and the one-step update for a single character
module b32c_core
   import b32c_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         step,
   input  logic [7:0]   character,
   input  logic         end_mark,
   input  logic [7:0]   crc_group,
   input  logic [12:0]  dest_bits,
   output step_out_type result
);

   logic [12:0] bits_done_ff,    bits_done_in;
   logic [7:0]  partial_byte_ff, partial_byte_in;
   logic [4:0]  running_crc_ff,  running_crc_in;
   logic [7:0]  group_count_ff,  group_count_in;
   logic        stopped_ff,      stopped_in;
   logic [1:0]  error_code_ff,   error_code_in;

   logic [12:0] limit;
   logic [12:0] room;
   logic [2:0]  sbits;
   logic [2:0]  offset;
   logic [4:0]  sym_mask;
   logic [4:0]  sym;
   logic        sym_ok;
   logic [5:0]  lookup;
   logic [12:0] window;
   logic [3:0]  fill;
   logic        skip;
   logic [1:0]  end_status;
   rsp_item_type data_item;
   rsp_item_type stat_item;

   assign limit  = (dest_bits > MAX_BITS) ? MAX_BITS : dest_bits;
   assign room   = limit - bits_done_ff;
   assign sbits  = (room > 13'd5) ? 3'd5 : room[2:0];
   assign offset = bits_done_ff[2:0];
   assign lookup = symbol_of(character);
   assign sym_ok = lookup[5];
   assign sym    = lookup[4:0];
   assign skip   = (character == CHAR_SPACE) || (character == CHAR_DASH) ||
                   ((character >= CHAR_WS_LO) && (character <= CHAR_WS_HI));

   // Keep only the top sbits bits of the symbol, then line it up after the filled bits
   assign sym_mask = 5'h1F << (3'd5 - sbits);
   assign window   = {partial_byte_ff, 5'b00000} |
                     ({8'h00, sym & sym_mask} << (4'd8 - {1'b0, offset}));
   assign fill     = {1'b0, offset} + {1'b0, sbits};

   assign end_status = ((error_code_ff == STATUS_OK) && (crc_group != 8'd0) &&
                        (group_count_ff != 8'd0)) ? STATUS_INCOMPLETE : error_code_ff;

   // Next state and results
   always_comb begin
      bits_done_in    = bits_done_ff;
      partial_byte_in = partial_byte_ff;
      running_crc_in  = running_crc_ff;
      group_count_in  = group_count_ff;
      stopped_in      = stopped_ff;
      error_code_in   = error_code_ff;

      data_item            = '0;
      data_item.kind       = KIND_DATA;
      stat_item            = '0;
      stat_item.kind       = KIND_STATUS;
      stat_item.last       = 1'b1;
      result               = '0;

      if (end_mark) begin
         stat_item.status = end_status;
         if (end_status == STATUS_OK) begin
            stat_item.bit_count = bits_done_ff;
         end
         if ((end_status == STATUS_OK) && (offset != 3'd0)) begin
            data_item.byte_value = partial_byte_ff;
            data_item.byte_index = bits_done_ff[11:3];
            result.item0 = data_item;
            result.item1 = stat_item;
            result.count = 2'd2;
         end else begin
            result.item0 = stat_item;
            result.count = 2'd1;
         end
         bits_done_in    = '0;
         partial_byte_in = '0;
         running_crc_in  = '0;
         group_count_in  = '0;
         stopped_in      = 1'b0;
         error_code_in   = STATUS_OK;
      end else if ((error_code_ff != STATUS_OK) || stopped_ff || skip) begin
         // dropped
      end else if (!sym_ok) begin
         error_code_in = STATUS_BAD_SYMBOL;
      end else if ((crc_group != 8'd0) && (group_count_ff == crc_group)) begin
         // check symbol closes the group
         if (running_crc_ff != sym) begin
            error_code_in = STATUS_CRC_ERROR;
         end else begin
            group_count_in = '0;
            running_crc_in = '0;
         end
      end else begin
         if (crc_group != 8'd0) begin
            running_crc_in = crc5_step(sym, running_crc_ff);
            group_count_in = group_count_ff + 8'd1;
         end
         if (bits_done_ff >= limit) begin
            stopped_in = 1'b1;
         end else begin
            bits_done_in = bits_done_ff + {10'd0, sbits};
            if (fill >= 4'd8) begin
               data_item.byte_value = window[12:5];
               data_item.byte_index = bits_done_ff[11:3];
               result.item0 = data_item;
               result.count = 2'd1;
               partial_byte_in = {window[4:0], 3'b000};
            end else begin
               partial_byte_in = window[12:5];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bits_done_ff    <= '0;
         partial_byte_ff <= '0;
         running_crc_ff  <= '0;
         group_count_ff  <= '0;
         stopped_ff      <= 1'b0;
         error_code_ff   <= STATUS_OK;
      end else if (step) begin
         bits_done_ff    <= bits_done_in;
         partial_byte_ff <= partial_byte_in;
         running_crc_ff  <= running_crc_in;
         group_count_ff  <= group_count_in;
         stopped_ff      <= stopped_in;
         error_code_ff   <= error_code_in;
      end
   end

endmodule

// ===== src/base32_crc5_group_decoder.sv =====
`timescale 1ns / 1ps

// Streaming Base32 decoder with optional CRC5 check symbols. One character is
// taken per cycle into an input register when req_tready is high; decoding, CRC
// and bit packing move it from that register into a two-entry result buffer,
// so a character yields at most one data byte, and the block sustains one
// character per clock while rsp_tready is high. An end marker yields up to two
// results (a flushed partial byte, then the status with tlast) and is taken only
// into a buffer that empties in that cycle, so it can wait while the buffer
// drains. The user must write crc_group and dest_bits through the csr_ port
// between strings; the block does not enforce this. csr_ready is always high.
module base32_crc5_group_decoder
   import b32c_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // input characters
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] character
   input  logic        req_tlast,   // end_mark
   // results
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [7:0] byte_value, [16:8] byte_index,
                                    // [18:17] status, [31:19] bit_count
   output logic        rsp_tuser,   // kind
   output logic        rsp_tlast,   // last
   // configuration writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [12:0] csr_data
);

   logic [7:0]   crc_group_ff;
   logic [12:0]  dest_bits_ff;
   logic         in_valid_ff;
   logic [7:0]   in_char_ff;
   logic         in_end_ff;
   rsp_item_type queue_ff [2];
   rsp_item_type queue_in [2];
   logic [1:0]   count_ff, count_in;
   logic         pop;
   logic         fire;
   logic [1:0]   base;
   logic [1:0]   pushed;
   step_out_type step_out;

   // Configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_group_ff <= 8'd0;
         dest_bits_ff <= MAX_BITS;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_CRC_GROUP: crc_group_ff <= csr_data[7:0];
            CSR_DEST_BITS: dest_bits_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Buffer occupancy left after this cycle's transfer out
   assign pop  = rsp_tvalid && rsp_tready;
   assign base = count_ff - {1'b0, pop};
   assign fire = in_valid_ff && ((base == 2'd0) || ((base == 2'd1) && !in_end_ff));
   assign req_tready = !in_valid_ff || fire;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_char_ff <= req_tdata;
         in_end_ff  <= req_tlast;
      end
   end

   b32c_core u_core (
      .clock     (clock),
      .reset     (reset),
      .step      (fire),
      .character (in_char_ff),
      .end_mark  (in_end_ff),
      .crc_group (crc_group_ff),
      .dest_bits (dest_bits_ff),
      .result    (step_out)
   );

   assign pushed = fire ? step_out.count : 2'd0;

   // Result buffer: slot 0 is the head, shifted on each transfer out
   always_comb begin
      queue_in[0] = queue_ff[0];
      queue_in[1] = queue_ff[1];
      if (base == 2'd1) begin
         queue_in[0] = pop ? queue_ff[1] : queue_ff[0];
         if (pushed != 2'd0) begin
            queue_in[1] = step_out.item0;
         end
      end else if (base == 2'd0) begin
         if (pushed != 2'd0) begin
            queue_in[0] = step_out.item0;
         end
         if (pushed == 2'd2) begin
            queue_in[1] = step_out.item1;
         end
      end
      count_in = base + pushed;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      queue_ff[0] <= queue_in[0];
      queue_ff[1] <= queue_in[1];
   end

   assign rsp_tvalid = (count_ff != 2'd0);
   assign rsp_tdata  = {queue_ff[0].bit_count, queue_ff[0].status,
                        queue_ff[0].byte_index, queue_ff[0].byte_value};
   assign rsp_tuser  = queue_ff[0].kind;
   assign rsp_tlast  = queue_ff[0].last;

endmodule
